// ===== rtl/core/event_timer_oneshot_periodic_assert.svh =====
// Assertion macros shared by the event timer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef EVENT_TIMER_ONESHOT_PERIODIC_ASSERT_SVH
`define EVENT_TIMER_ONESHOT_PERIODIC_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define EVTMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("event timer assertion failed");

// Next-cycle implication, disabled in reset.
`define EVTMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("event timer assertion failed");

`endif

// ===== rtl/core/evtmr_pkg.sv =====
// Package of the event timer: widths, codes, item structs, sequencer states.
// No dependencies; used by evtmr_div and event_timer_oneshot_periodic.
package evtmr_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W     = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MIN_PERIOD = DATA_W'(100);
  localparam logic [DATA_W-1:0] ALL_ONES   = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 3'd0,
    REQ_START      = 3'd1,
    REQ_STOP       = 3'd2,
    REQ_CONNECT    = 3'd3,
    REQ_DISCONNECT = 3'd4,
    REQ_INFO       = 3'd5
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK            = 3'd0,
    ST_BAD_PERIOD    = 3'd1,
    ST_NOT_CONNECTED = 3'd2,
    ST_BUSY          = 3'd3,
    ST_ONESHOT_PAST  = 3'd4,
    ST_ALREADY_CONN  = 3'd5,
    ST_NO_QUEUE      = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NUMBER = 1'b0,
    CFG_TIMER_NUMBER   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] phase_base;
    logic [DATA_W-1:0] period_in;
    logic [DATA_W-1:0] event_name;
    logic [DATA_W-1:0] word_one;
    logic [DATA_W-1:0] word_two;
    logic              queue_exists;
  } req_t;

  typedef struct packed {
    logic              is_event;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] ev_source;
    logic [DATA_W-1:0] ev_word_one;
    logic [DATA_W-1:0] ev_word_two;
    logic [DATA_W-1:0] ev_time;
    logic [DATA_W-1:0] wait_left;
    logic              is_running;
    logic [DATA_W-1:0] cur_expiry;
    logic [DATA_W-1:0] cur_period;
    logic              last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_FIRE_CMP,
    S_FIRE_ADD,
    S_POST,
    S_OS_CMP,
    S_ADD_NP,
    S_ADD_BP,
    S_CMP_T,
    S_DIV_NOW,
    S_SUB_R1,
    S_DIV_BASE,
    S_ADD_R2,
    S_CMP_AL,
    S_ADD_AL,
    S_WAIT_LEFT,
    S_OUT_EV,
    S_OUT_ST
  } state_e;

endpackage

// ===== rtl/core/event_timer_oneshot_periodic.sv =====
// Top level of the one-shot / periodic event timer with its request sequencer.
// Depends on evtmr_pkg, evtmr_div and event_timer_oneshot_periodic_assert.svh.
//
// One event timer driven by host requests (tick, start, stop, connect, disconnect,
// info). A request is taken when start is high and busy is low; busy then
// stays high until its last result has been shown. Every request yields one status
// result (last = 1), preceded by one event result when a due expiry fires while the
// timer is connected. Each result sits on res_o for exactly one cycle, flagged by
// res_strobe_o; the receiver cannot stall, so capture it in that cycle. A periodic
// start with a nonzero base whose first phase point (base plus period) is already
// reached runs phase alignment: two 64-bit remainders go through the bit-serial
// divider, one after the other. All other arithmetic shares one 64-bit
// add/subtract unit, one operation per sequencer step. A zero wait_left means
// another expiry is already due: send another tick. Write process_number and
// timer_number over the cfg port only while busy is low.
`include "event_timer_oneshot_periodic_assert.svh"

module event_timer_oneshot_periodic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  evtmr_pkg::req_t                 req_i,
  output logic                            res_strobe_o,
  output evtmr_pkg::res_t                 res_o,
  input  logic                            cfg_we_i,
  input  logic [evtmr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [evtmr_pkg::HALF_W-1:0]    cfg_wdata_i
);
  import evtmr_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // latched request and working registers
  req_t              req_q, req_d;
  status_e           status_q, status_d;
  logic              ev_flag_q, ev_flag_d;
  logic [DATA_W-1:0] ev_time_q, ev_time_d;
  logic [DATA_W-1:0] tmp_q, tmp_d;
  logic [DATA_W-1:0] wait_q, wait_d;

  // timer state
  logic              running_q, running_d;
  logic              connected_q, connected_d;
  logic [DATA_W-1:0] expiry_q, expiry_d;
  logic [DATA_W-1:0] period_q, period_d;
  logic [DATA_W-1:0] source_q, source_d;
  logic [DATA_W-1:0] data1_q, data1_d;
  logic [DATA_W-1:0] data2_q, data2_d;

  // configuration
  logic [HALF_W-1:0] proc_num_q;
  logic [HALF_W-1:0] tmr_num_q;

  // shared add/subtract unit
  logic [DATA_W-1:0] au_a, au_b;
  logic              au_sub;
  logic [DATA_W:0]   au_sum;
  logic [DATA_W-1:0] au_res, au_sat;
  logic              au_cout;

  // remainder unit
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic              div_done;
  logic [DATA_W-1:0] div_rem;

  logic bad_period, per_zero, base_zero, accept;

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);
  assign per_zero   = (req_q.period_in == '0);
  assign base_zero  = (req_q.phase_base == '0);
  assign bad_period = !per_zero && (req_q.period_in < MIN_PERIOD);

  // For subtraction the carry out is the "no borrow" flag: a >= b.
  assign au_sum  = {1'b0, au_a} + {1'b0, au_b ^ {DATA_W{au_sub}}} + (DATA_W + 1)'(au_sub);
  assign au_res  = au_sum[DATA_W-1:0];
  assign au_cout = au_sum[DATA_W];
  assign au_sat  = au_cout ? ALL_ONES : au_res;

  // Operand selection for the shared unit, one operation per step.
  always_comb begin
    au_a   = req_q.now;
    au_b   = '0;
    au_sub = 1'b0;
    unique case (state_q)
      S_FIRE_CMP:  begin au_a = req_q.now;        au_b = expiry_q;         au_sub = 1'b1; end
      S_FIRE_ADD:  begin au_a = expiry_q;         au_b = period_q;                        end
      S_OS_CMP:    begin au_a = req_q.now;        au_b = req_q.phase_base; au_sub = 1'b1; end
      S_ADD_NP:    begin au_a = req_q.now;        au_b = req_q.period_in;                 end
      S_ADD_BP:    begin au_a = req_q.phase_base; au_b = req_q.period_in;                 end
      S_CMP_T:     begin au_a = req_q.now;        au_b = tmp_q;            au_sub = 1'b1; end
      S_SUB_R1:    begin au_a = req_q.now;        au_b = tmp_q;            au_sub = 1'b1; end
      S_ADD_R2:    begin au_a = tmp_q;            au_b = div_rem;                         end
      S_CMP_AL:    begin au_a = tmp_q;            au_b = req_q.now;        au_sub = 1'b1; end
      S_ADD_AL:    begin au_a = tmp_q;            au_b = req_q.period_in;                 end
      S_WAIT_LEFT: begin au_a = expiry_q;         au_b = req_q.now;        au_sub = 1'b1; end
      default: ;
    endcase
  end

  evtmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (req_q.period_in),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DECODE;
      S_DECODE: begin
        unique case (req_q.req_type)
          REQ_TICK, REQ_STOP, REQ_DISCONNECT, REQ_INFO: state_d = S_FIRE_CMP;
          REQ_START: state_d = (bad_period || !connected_q) ? S_WAIT_LEFT : S_FIRE_CMP;
          default:   state_d = S_WAIT_LEFT;
        endcase
      end
      S_FIRE_CMP: begin
        state_d = (running_q && au_cout && (period_q != '0)) ? S_FIRE_ADD : S_POST;
      end
      S_FIRE_ADD: state_d = S_POST;
      S_POST: begin
        priority if (req_q.req_type != REQ_START) state_d = S_WAIT_LEFT;
        else if (running_q) state_d = S_WAIT_LEFT;
        else if (per_zero)  state_d = S_OS_CMP;
        else if (base_zero) state_d = S_ADD_NP;
        else                state_d = S_ADD_BP;
      end
      S_OS_CMP:    state_d = S_WAIT_LEFT;
      S_ADD_NP:    state_d = S_WAIT_LEFT;
      S_ADD_BP:    state_d = S_CMP_T;
      S_CMP_T:     state_d = au_cout ? S_DIV_NOW : S_WAIT_LEFT;
      S_DIV_NOW:   if (div_done) state_d = S_SUB_R1;
      S_SUB_R1:    state_d = S_DIV_BASE;
      S_DIV_BASE:  if (div_done) state_d = S_ADD_R2;
      S_ADD_R2:    state_d = S_CMP_AL;
      S_CMP_AL:    state_d = au_cout ? S_WAIT_LEFT : S_ADD_AL;
      S_ADD_AL:    state_d = S_WAIT_LEFT;
      S_WAIT_LEFT: state_d = ev_flag_q ? S_OUT_EV : S_OUT_ST;
      S_OUT_EV:    state_d = S_OUT_ST;
      S_OUT_ST:    state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Register updates per step.
  always_comb begin
    req_d       = req_q;
    status_d    = status_q;
    ev_flag_d   = ev_flag_q;
    ev_time_d   = ev_time_q;
    tmp_d       = tmp_q;
    wait_d      = wait_q;
    running_d   = running_q;
    connected_d = connected_q;
    expiry_d    = expiry_q;
    period_d    = period_q;
    source_d    = source_q;
    data1_d     = data1_q;
    data2_d     = data2_q;
    unique case (state_q)
      S_IDLE: begin
        // latch the item and clear per-request flags
        if (accept) begin
          req_d     = req_i;
          status_d  = ST_OK;
          ev_flag_d = 1'b0;
        end
      end
      S_DECODE: begin
        unique case (req_q.req_type)
          REQ_START: begin
            priority if (bad_period) status_d = ST_BAD_PERIOD;
            else if (!connected_q)   status_d = ST_NOT_CONNECTED;
          end
          REQ_CONNECT: begin
            priority if (!req_q.queue_exists) status_d = ST_NO_QUEUE;
            else if (connected_q) status_d = ST_ALREADY_CONN;
            else begin
              connected_d = 1'b1;
              source_d    = (req_q.event_name != '0) ? req_q.event_name
                                                     : {proc_num_q, tmr_num_q};
              data1_d     = req_q.word_one;
              data2_d     = req_q.word_two;
            end
          end
          default: ;
        endcase
      end
      S_FIRE_CMP: begin
        // due expiry: record the event, stop a one-shot
        if (running_q && au_cout) begin
          ev_flag_d = connected_q;
          ev_time_d = expiry_q;
          if (period_q == '0) running_d = 1'b0;
        end
      end
      S_FIRE_ADD: expiry_d = au_sat;
      S_POST: begin
        unique case (req_q.req_type)
          REQ_STOP: running_d = 1'b0;
          REQ_DISCONNECT: begin
            running_d = 1'b0;
            if (!connected_q) status_d = ST_NOT_CONNECTED;
            else              connected_d = 1'b0;
          end
          REQ_START: if (running_q) status_d = ST_BUSY;
          default: ;
        endcase
      end
      S_OS_CMP: begin
        if (au_cout) begin
          status_d = ST_ONESHOT_PAST;
        end else begin
          expiry_d  = req_q.phase_base;
          period_d  = req_q.period_in;
          running_d = 1'b1;
        end
      end
      S_ADD_NP: begin
        expiry_d  = au_sat;
        period_d  = req_q.period_in;
        running_d = 1'b1;
      end
      S_ADD_BP: tmp_d = au_sat;
      S_CMP_T: begin
        // still before the first phase point: arm there
        if (!au_cout) begin
          expiry_d  = tmp_q;
          period_d  = req_q.period_in;
          running_d = 1'b1;
        end
      end
      S_DIV_NOW: if (div_done) tmp_d = div_rem;
      S_SUB_R1:  tmp_d = au_res;
      S_DIV_BASE: ;
      S_ADD_R2:  tmp_d = au_sat;
      S_CMP_AL: begin
        if (au_cout) begin
          expiry_d  = tmp_q;
          period_d  = req_q.period_in;
          running_d = 1'b1;
        end
      end
      S_ADD_AL: begin
        expiry_d  = au_sat;
        period_d  = req_q.period_in;
        running_d = 1'b1;
      end
      S_WAIT_LEFT: begin
        wait_d = running_q ? (au_cout ? au_res : '0) : ALL_ONES;
      end
      default: ;
    endcase
  end

  // Sequencer outputs: divider kicks and the result items.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = req_q.now;
    res_strobe_o = 1'b0;
    res_o             = '0;
    res_o.wait_left   = wait_q;
    res_o.is_running  = running_q;
    res_o.cur_expiry  = expiry_q;
    res_o.cur_period  = period_q;
    unique case (state_q)
      S_CMP_T: div_start = au_cout;
      S_SUB_R1: begin
        div_start    = 1'b1;
        div_dividend = req_q.phase_base;
      end
      S_OUT_EV: begin
        res_strobe_o      = 1'b1;
        res_o.is_event    = 1'b1;
        res_o.ev_source   = source_q;
        res_o.ev_word_one = data1_q;
        res_o.ev_word_two = data2_q;
        res_o.ev_time     = ev_time_q;
      end
      S_OUT_ST: begin
        res_strobe_o = 1'b1;
        res_o.status = status_q;
        res_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      ev_flag_q   <= 1'b0;
      running_q   <= 1'b0;
      connected_q <= 1'b0;
      expiry_q    <= '0;
      period_q    <= '0;
      source_q    <= '0;
      data1_q     <= '0;
      data2_q     <= '0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      ev_flag_q   <= ev_flag_d;
      running_q   <= running_d;
      connected_q <= connected_d;
      expiry_q    <= expiry_d;
      period_q    <= period_d;
      source_q    <= source_d;
      data1_q     <= data1_d;
      data2_q     <= data2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ev_time_q <= ev_time_d;
    tmp_q     <= tmp_d;
    wait_q    <= wait_d;
  end

  // Configuration writes land directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_num_q <= '0;
      tmr_num_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PROCESS_NUMBER) proc_num_q <= cfg_wdata_i;
      else                                 tmr_num_q  <= cfg_wdata_i;
    end
  end

  `EVTMR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `EVTMR_ASSERT_IMP(a_result_busy, res_strobe_o, busy)
  `EVTMR_ASSERT_NXT(a_event_then_status, res_strobe_o && res_o.is_event,
                    res_strobe_o && !res_o.is_event && res_o.last)
  `EVTMR_ASSERT_NXT(a_last_idle, res_strobe_o && res_o.last, !busy && !res_strobe_o)

endmodule

// ===== rtl/core/evtmr_div.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on evtmr_pkg and event_timer_oneshot_periodic_assert.svh.
`include "event_timer_oneshot_periodic_assert.svh"

module evtmr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [evtmr_pkg::DATA_W-1:0] dividend_i,
  input  logic [evtmr_pkg::DATA_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [evtmr_pkg::DATA_W-1:0] rem_o
);
  import evtmr_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              last_step;

  assign shifted   = {rem_q, dvd_q[DATA_W-1]};
  assign trial     = shifted - {1'b0, dvs_q};
  assign last_step = (cnt_q == CNT_W'(DATA_W - 1));

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      // keep the trial difference when it did not borrow
      rem_d = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd_d = {dvd_q[DATA_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (last_step) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `EVTMR_ASSERT_IMP(a_div_start_idle, start_i, !run_q)
  `EVTMR_ASSERT_NXT(a_div_done_pulse, done_o, !done_o)
  `EVTMR_ASSERT_NXT(a_div_last_done, run_q && last_step && !start_i, done_o && !run_q)

endmodule
